// File: rtl/deque_with_value_search_unit_macros.svh
// Assertion macros used by the deque with value search controller.
`ifndef DEQUE_WITH_VALUE_SEARCH_UNIT_MACROS_SVH
`define DEQUE_WITH_VALUE_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DQVS_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DQVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DQVS_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg)
`define DQVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/dqvs_pkg.sv
package dqvs_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;

    localparam logic signed [DATA_W-1:0] POP_EMPTY_DATA = -32'sd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     hit;
        logic                     error;
    } t_result;

endpackage

// File: rtl/dqvs_if.sv
interface dqvs_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

interface dqvs_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;
    logic               hit;
    logic               error;

    modport source (output valid, output data, output hit, output error, input ready);
    modport sink (input valid, input data, input hit, input error, output ready);
endinterface

// File: rtl/dqvs_mem.sv
module dqvs_mem import dqvs_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/dqvs_ctrl.sv
`include "deque_with_value_search_unit_macros.svh"

module dqvs_ctrl import dqvs_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dqvs_req_if.sink          i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [DATA_W-1:0] o_mem_wdata,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [DATA_W-1:0] i_mem_rdata
);

    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);
    localparam logic [AW-1:0] SLOT_LAST = AW'(DEPTH - 1);

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_slot, n_slot;
    logic [AW-1:0]     r_wslot, n_wslot;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [DATA_W-1:0] r_val, n_val;
    t_result           r_res, n_res;

    logic              full;
    logic              empty;
    logic              at_last;
    logic [AW-1:0]     next_slot;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [AW+1:0] s;
        s = {2'b00, head} + (AW+2)'(pos);
        if (s >= (AW+2)'(DEPTH)) begin
            s = s - (AW+2)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
        return (s == '0) ? SLOT_LAST : s - AW'(1);
    endfunction

    assign full      = (r_count == COUNT_MAX);
    assign empty     = (r_count == '0);
    assign at_last   = (r_pos == r_count - CW'(1));
    assign next_slot = slot_next(r_slot);
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_slot  <= n_slot;
        r_wslot <= n_wslot;
        r_cmd   <= n_cmd;
        r_val   <= n_val;
        r_res   <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_pos       = r_pos;
        n_slot      = r_slot;
        n_wslot     = r_wslot;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_res       = r_res;
        i_req.ready = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wslot;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_slot;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_cmd   = i_req.cmd;
                    n_val   = i_req.value;
                    n_res   = '0;
                    n_state = ST_RESP;
                    unique case (i_req.cmd) inside
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_res.error = 1'b1;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = slot_prev(r_head);
                                o_mem_wdata = i_req.value;
                                n_head      = slot_prev(r_head);
                                n_count     = r_count + CW'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_res.error = 1'b1;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = slot_of(r_head, r_count);
                                o_mem_wdata = i_req.value;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (empty) begin
                                n_res.data  = POP_EMPTY_DATA;
                                n_res.error = 1'b1;
                            end else begin
                                o_mem_raddr = (i_req.cmd == CMD_POP_FRONT) ? r_head
                                            : slot_of(r_head, r_count - CW'(1));
                                n_slot      = o_mem_raddr;
                                n_state     = ST_POP;
                            end
                        end
                        CMD_CONTAINS, CMD_REMOVE: begin
                            if (empty) begin
                                n_res.error = (i_req.cmd == CMD_REMOVE);
                            end else begin
                                o_mem_raddr = r_head;
                                n_slot      = r_head;
                                n_pos       = '0;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                            n_res.error = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_res.data = i_mem_rdata;
                n_count    = r_count - CW'(1);
                if (r_cmd == CMD_POP_FRONT) begin
                    n_head = slot_next(r_head);
                end
                n_state = ST_RESP;
            end
            ST_SCAN: begin
                if (i_mem_rdata == r_val) begin
                    n_res.hit = 1'b1;
                    if (r_cmd == CMD_CONTAINS) begin
                        n_state = ST_RESP;
                    end else if (at_last) begin
                        n_count = r_count - CW'(1);
                        n_state = ST_RESP;
                    end else begin
                        o_mem_raddr = next_slot;
                        n_wslot     = r_slot;
                        n_slot      = next_slot;
                        n_pos       = r_pos + CW'(1);
                        n_state     = ST_SHIFT;
                    end
                end else if (at_last) begin
                    n_res.error = (r_cmd == CMD_REMOVE);
                    n_state     = ST_RESP;
                end else begin
                    o_mem_raddr = next_slot;
                    n_slot      = next_slot;
                    n_pos       = r_pos + CW'(1);
                end
            end
            ST_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_wslot;
                o_mem_wdata = i_mem_rdata;
                n_wslot     = r_slot;
                if (at_last) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_RESP;
                end else begin
                    o_mem_raddr = next_slot;
                    n_slot      = next_slot;
                    n_pos       = r_pos + CW'(1);
                end
            end
            ST_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `DQVS_ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= COUNT_MAX, "Entry count exceeds the store depth.")
    `DQVS_ASSERT_HOLDS(a_scan_in_range, i_clk, i_rst_n, r_state == ST_SCAN || r_state == ST_SHIFT, r_pos < r_count, "Scan position runs past the stored entries.")
    `DQVS_ASSERT_HOLDS(a_shift_no_overlap, i_clk, i_rst_n, r_state == ST_SHIFT, o_mem_waddr != o_mem_raddr, "Shift writes the entry it is reading.")
    `DQVS_ASSERT_NEXT(a_resp_to_idle, i_clk, i_rst_n, o_res_valid && i_res_ready, r_state == ST_IDLE, "Unit did not return to idle after handing over a result.")

endmodule

// File: rtl/deque_with_value_search_unit.sv
// Double-ended queue of signed 32-bit values with value search and removal.
// Requests arrive on i_req (cmd, value) and each request yields exactly one
// response on o_rsp (data, hit, error); both channels use valid/ready.
// Entries sit in a DEPTH-entry synchronous memory addressed as a ring by a head
// index and an entry count.
// A push writes the memory as the request is accepted; a pop takes the read data
// in a separate state. Contains and remove walk the memory one entry per cycle
// through its single read port; a remove that shifts the entries behind the match
// reads one entry and writes the previous slot each cycle.
// After the memory work the response is registered in the controller and then in
// the output register before it reaches o_rsp.
// A completed response waits in an output register, and one more can be held
// inside the unit while the receiver stalls; after that no request is accepted.
// Reset empties the queue at once and drops any pending response; memory
// contents are not cleared, and read data is only used from entries that were written.
module deque_with_value_search_unit import dqvs_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dqvs_req_if.sink  i_req,
    dqvs_rsp_if.source o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              r_out_valid;
    t_result           r_out;

    dqvs_ctrl #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .o_mem_we   (mem_we),
        .o_mem_waddr(mem_waddr),
        .o_mem_wdata(mem_wdata),
        .o_mem_raddr(mem_raddr),
        .i_mem_rdata(mem_rdata)
    );

    dqvs_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out.data;
    assign o_rsp.hit   = r_out.hit;
    assign o_rsp.error = r_out.error;

endmodule
